/* rtl/ecbd_pkg.sv */
// Shared types, constants and the helper function of the eye closure and blink detector.
package ecbd_pkg;

    localparam int COORD_W       = 17;
    localparam int HIST_DEPTH    = 10;
    localparam int PAIRS_PER_EYE = 3;
    localparam int PAIR_SLOTS    = 3;
    localparam int NUM_EYES      = 2;

    localparam int HIST_AW  = $clog2(HIST_DEPTH);
    localparam int FILL_W   = $clog2(HIST_DEPTH + 1);
    localparam int SUM_W    = COORD_W + FILL_W;
    localparam int CNT_W    = $clog2(PAIRS_PER_EYE + 1);
    localparam int ACC_W    = COORD_W + CNT_W;
    localparam int RECIP_SH = ACC_W + 2;
    localparam int RECIP3   = (2 ** RECIP_SH + 2) / 3;
    localparam int PROD3_W  = ACC_W + RECIP_SH;

    localparam int DROP_W   = 7;
    localparam int WARM_W   = 4;
    localparam int RUN_W    = 16;
    localparam int PDROP_W  = DROP_W + SUM_W;
    localparam int PNAP_W   = FILL_W + COORD_W;
    localparam int CMP_W    = SUM_W + 8;
    localparam int PCT_SCALE = 100;

    localparam int STAT_W   = 2;
    localparam int DANGER_W = 2;
    localparam int DIV_CW   = $clog2(SUM_W + 1);

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_MIN_DIST = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WARMUP   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DROP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_MIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_MAX = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WARN     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ALARM    = 3'd6;

    localparam logic [COORD_W-1:0] RST_MIN_DIST  = 17'd25;
    localparam logic [WARM_W-1:0]  RST_WARMUP    = 4'd5;
    localparam logic [DROP_W-1:0]  RST_DROP      = 7'd30;
    localparam logic [RUN_W-1:0]   RST_BLINK_MIN = 16'd2;
    localparam logic [RUN_W-1:0]   RST_BLINK_MAX = 16'd15;
    localparam logic [RUN_W-1:0]   RST_WARN      = 16'd15;
    localparam logic [RUN_W-1:0]   RST_ALARM     = 16'd30;

    localparam logic [STAT_W-1:0] ST_EVAL    = 2'd0;
    localparam logic [STAT_W-1:0] ST_WARMUP  = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    localparam logic [DANGER_W-1:0] DNG_NONE  = 2'd0;
    localparam logic [DANGER_W-1:0] DNG_WARN  = 2'd1;
    localparam logic [DANGER_W-1:0] DNG_ALARM = 2'd2;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord [NUM_EYES-1:0][PAIR_SLOTS-1:0] top;
        t_coord [NUM_EYES-1:0][PAIR_SLOTS-1:0] bot;
    } t_frame;

    typedef struct packed {
        logic [COORD_W-1:0] min_dist;
        logic [WARM_W-1:0]  warmup;
        logic [DROP_W-1:0]  drop;
        logic [RUN_W-1:0]   blink_min;
        logic [RUN_W-1:0]   blink_max;
        logic [RUN_W-1:0]   warn;
        logic [RUN_W-1:0]   alarm;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic pair_sum;
        logic mean;
        logic aper;
        logic upd;
        logic mul;
        logic cmp;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic frame_ok;
        logic div_done;
        logic out_free;
    } t_stat;

    // Divides a pair-distance sum by a pair count of one to three; a count of zero gives zero.
    function automatic t_coord eye_mean(logic [ACC_W-1:0] acc, logic [CNT_W-1:0] cnt);
        logic [PROD3_W-1:0] prod;
        logic [PROD3_W-1:0] quo;
        t_coord             res;
        prod = PROD3_W'(acc) * PROD3_W'(RECIP3);
        quo  = prod >> RECIP_SH;
        priority if (cnt == CNT_W'(1)) begin
            res = acc[COORD_W-1:0];
        end else if (cnt == CNT_W'(2)) begin
            res = acc[COORD_W:1];
        end else if (cnt == CNT_W'(3)) begin
            res = quo[COORD_W-1:0];
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

/* rtl/ecbd_div.sv */
// Restoring serial divider for the history average, one quotient bit per cycle.
module ecbd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ecbd_pkg::SUM_W-1:0]  i_dividend,
    input  logic [ecbd_pkg::FILL_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [ecbd_pkg::SUM_W-1:0]  o_quot
);
    import ecbd_pkg::*;

    logic [FILL_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_done;
    logic [FILL_W:0]   w_shift;
    logic [FILL_W:0]   w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, i_divisor};
    assign w_diff  = w_shift - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CW'(SUM_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CW'(1);
            if (r_cnt == DIV_CW'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[FILL_W-1:0] : w_shift[FILL_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* rtl/ecbd_ctrl.sv */
// Sequencer that steps the datapath through one frame at a time.
module ecbd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ecbd_pkg::t_stat i_stat,
    output ecbd_pkg::t_cmd  o_cmd
);
    import ecbd_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIST     = 4'd1;
    localparam logic [3:0] S_MEAN     = 4'd2;
    localparam logic [3:0] S_APER     = 4'd3;
    localparam logic [3:0] S_UPD      = 4'd4;
    localparam logic [3:0] S_MUL      = 4'd5;
    localparam logic [3:0] S_CMP      = 4'd6;
    localparam logic [3:0] S_DIV_GO   = 4'd7;
    localparam logic [3:0] S_DIV_WAIT = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DIST;
                end
            end
            S_DIST: begin
                o_cmd.pair_sum = 1'b1;
                n_state        = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.mean = 1'b1;
                n_state    = i_stat.frame_ok ? S_APER : S_DIV_GO;
            end
            S_APER: begin
                o_cmd.aper = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/ecbd_dp.sv */
// Datapath: eye means, aperture history ring, closure test, run tracking and result register.
module ecbd_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ecbd_pkg::t_cfg                 i_cfg,
    input  ecbd_pkg::t_frame               i_frame,
    input  ecbd_pkg::t_cmd                 i_cmd,
    output ecbd_pkg::t_stat                o_stat,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [ecbd_pkg::STAT_W-1:0]    o_status,
    output logic [ecbd_pkg::DANGER_W-1:0]  o_danger_level,
    output logic [ecbd_pkg::COORD_W-1:0]   o_aperture,
    output logic [ecbd_pkg::COORD_W-1:0]   o_history_average,
    output logic                           o_eyes_closed,
    output logic [ecbd_pkg::RUN_W-1:0]     o_closed_frames,
    output logic [ecbd_pkg::RUN_W-1:0]     o_blink_count
);
    import ecbd_pkg::*;

    t_frame r_frame;

    logic [NUM_EYES-1:0][ACC_W-1:0] r_acc;
    logic [NUM_EYES-1:0][CNT_W-1:0] r_cnt;
    logic [NUM_EYES-1:0][ACC_W-1:0] n_acc;
    logic [NUM_EYES-1:0][CNT_W-1:0] n_cnt;
    t_coord [NUM_EYES-1:0]          r_mean;

    t_coord r_ap;
    t_coord r_old;
    t_coord r_hist [HIST_DEPTH];

    logic [SUM_W-1:0]   r_sum;
    logic [HIST_AW-1:0] r_wp;
    logic [FILL_W-1:0]  r_fill;
    logic [PDROP_W-1:0] r_p_drop;
    logic [PNAP_W-1:0]  r_p_nap;

    logic             r_flag;
    logic [RUN_W-1:0] r_run;
    logic [RUN_W-1:0] r_blinks;
    logic             n_flag;
    logic [RUN_W-1:0] n_run;
    logic [RUN_W-1:0] n_blinks;

    logic [STAT_W-1:0]   r_status;
    logic [DANGER_W-1:0] r_danger;
    logic [STAT_W-1:0]   n_status;
    logic [DANGER_W-1:0] n_danger;

    logic [COORD_W:0] w_ap_sum;
    logic [CMP_W-1:0] w_lhs;
    logic [CMP_W-1:0] w_rhs;
    logic             w_eval;
    logic             w_closed_now;

    logic             w_div_done;
    logic [SUM_W-1:0] w_quot;

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_frame <= i_frame;
        end
    end

    // Sum and count of the pair distances above the minimum, per eye.
    always_comb begin
        logic [COORD_W-1:0] d;
        for (int e = 0; e < NUM_EYES; e++) begin
            n_acc[e] = '0;
            n_cnt[e] = '0;
            for (int k = 0; k < PAIRS_PER_EYE; k++) begin
                d = (r_frame.top[e][k] >= r_frame.bot[e][k]) ?
                    r_frame.top[e][k] - r_frame.bot[e][k] :
                    r_frame.bot[e][k] - r_frame.top[e][k];
                if (d > i_cfg.min_dist) begin
                    n_acc[e] = n_acc[e] + ACC_W'(d);
                    n_cnt[e] = n_cnt[e] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_sum) begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
        if (i_cmd.mean) begin
            for (int e = 0; e < NUM_EYES; e++) begin
                r_mean[e] <= eye_mean(r_acc[e], r_cnt[e]);
            end
        end
    end

    assign o_stat.frame_ok = (r_cnt[0] != '0) && (r_cnt[1] != '0);

    assign w_ap_sum = {1'b0, r_mean[0]} + {1'b0, r_mean[1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.aper) begin
            r_ap  <= w_ap_sum[COORD_W:1];
            r_old <= r_hist[r_wp];
        end
        if (i_cmd.upd) begin
            r_hist[r_wp] <= r_ap;
        end
        if (i_cmd.mul) begin
            r_p_drop <= PDROP_W'(i_cfg.drop) * PDROP_W'(r_sum);
            r_p_nap  <= PNAP_W'(r_fill) * PNAP_W'(r_ap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.upd) begin
            if (r_fill == FILL_W'(HIST_DEPTH)) begin
                r_sum <= r_sum - SUM_W'(r_old) + SUM_W'(r_ap);
            end else begin
                r_sum  <= r_sum + SUM_W'(r_ap);
                r_fill <= r_fill + FILL_W'(1);
            end
            r_wp <= (r_wp == HIST_AW'(HIST_DEPTH - 1)) ? '0 : r_wp + HIST_AW'(1);
        end
    end

    // Closed when 100 * (sum - n * aperture) exceeds drop * sum.
    assign w_lhs        = CMP_W'(r_sum) * CMP_W'(PCT_SCALE);
    assign w_rhs        = CMP_W'(r_p_drop) + CMP_W'(r_p_nap) * CMP_W'(PCT_SCALE);
    assign w_closed_now = w_lhs > w_rhs;
    assign w_eval       = 32'(r_fill) >= 32'(i_cfg.warmup);

    always_comb begin
        n_flag   = r_flag;
        n_run    = r_run;
        n_blinks = r_blinks;
        n_status = ST_WARMUP;
        n_danger = DNG_NONE;
        if (w_eval) begin
            n_status = ST_EVAL;
            if (w_closed_now) begin
                if (!r_flag) begin
                    n_flag = 1'b1;
                    n_run  = RUN_W'(1);
                end else if (r_run != RUN_MAX) begin
                    n_run = r_run + RUN_W'(1);
                end
            end else if (r_flag) begin
                if ((r_run > i_cfg.blink_min) && (r_run < i_cfg.blink_max) &&
                    (r_blinks != RUN_MAX)) begin
                    n_blinks = r_blinks + RUN_W'(1);
                end
                n_flag = 1'b0;
                n_run  = '0;
            end
            priority if (n_run > i_cfg.alarm) begin
                n_danger = DNG_ALARM;
            end else if (n_run > i_cfg.warn) begin
                n_danger = DNG_WARN;
            end else begin
                n_danger = DNG_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= 1'b0;
            r_run    <= '0;
            r_blinks <= '0;
        end else if (i_cmd.cmp) begin
            r_flag   <= n_flag;
            r_run    <= n_run;
            r_blinks <= n_blinks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean) begin
            r_status <= ST_INVALID;
            r_danger <= DNG_NONE;
        end else if (i_cmd.cmp) begin
            r_status <= n_status;
            r_danger <= n_danger;
        end
    end

    ecbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status          <= r_status;
            o_danger_level    <= r_danger;
            o_aperture        <= o_stat.frame_ok ? r_ap : '0;
            o_history_average <= (r_fill == '0) ? '0 : w_quot[COORD_W-1:0];
            o_eyes_closed     <= r_flag;
            o_closed_frames   <= r_run;
            o_blink_count     <= r_blinks;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/eye_closure_blink_detector_unit.sv */
// Top level of the eye closure and blink detector: register file, sequencer and datapath.
//
// One input beat carries the top and bottom vertical landmark coordinates of three pairs
// per eye for one video frame; one output beat returns the frame's status, danger level,
// aperture, history average, closed flag, closed run length and blink count.
// Both channels use valid and stall. The block works on one frame at a time: o_in_stall
// is high from the cycle after a beat is accepted until the result is handed to the
// output register. A frame with a valid pair on both eyes passes the aperture, history
// update, multiply and compare steps; an invalid frame skips them and goes to the divider.
// The serial divider that forms the history average (one quotient bit per cycle over the
// 21-bit sum) is the longest step. The next frame can be accepted in the cycle after the
// result is loaded. The output register holds a result while i_out_stall is high; a
// finished frame waits for it to drain before it is loaded, and the input side stays
// stalled meanwhile. Configuration registers are to be written over the APB port while
// the block is idle; the block itself does not enforce this. Synchronous reset restores
// the register defaults and clears the history, the closed run and the blink count;
// history entries are written before they are ever read.
module eye_closure_blink_detector_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ecbd_pkg::ADDR_W-1:0]    paddr,
    input  logic [ecbd_pkg::DATA_W-1:0]    pwdata,
    output logic [ecbd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_left_top_y_1,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_left_top_y_2,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_left_top_y_3,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_left_bottom_y_1,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_left_bottom_y_2,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_left_bottom_y_3,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_right_top_y_1,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_right_top_y_2,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_right_top_y_3,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_right_bottom_y_1,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_right_bottom_y_2,
    input  logic [ecbd_pkg::COORD_W-1:0]   i_right_bottom_y_3,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ecbd_pkg::STAT_W-1:0]    o_status,
    output logic [ecbd_pkg::DANGER_W-1:0]  o_danger_level,
    output logic [ecbd_pkg::COORD_W-1:0]   o_aperture,
    output logic [ecbd_pkg::COORD_W-1:0]   o_history_average,
    output logic                           o_eyes_closed,
    output logic [ecbd_pkg::RUN_W-1:0]     o_closed_frames,
    output logic [ecbd_pkg::RUN_W-1:0]     o_blink_count
);
    import ecbd_pkg::*;

    t_cfg   r_cfg;
    t_frame w_frame;
    t_cmd   w_cmd;
    t_stat  w_stat;

    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_dist  <= RST_MIN_DIST;
            r_cfg.warmup    <= RST_WARMUP;
            r_cfg.drop      <= RST_DROP;
            r_cfg.blink_min <= RST_BLINK_MIN;
            r_cfg.blink_max <= RST_BLINK_MAX;
            r_cfg.warn      <= RST_WARN;
            r_cfg.alarm     <= RST_ALARM;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MIN_DIST:  r_cfg.min_dist  <= pwdata[COORD_W-1:0];
                REG_WARMUP:    r_cfg.warmup    <= pwdata[WARM_W-1:0];
                REG_DROP:      r_cfg.drop      <= pwdata[DROP_W-1:0];
                REG_BLINK_MIN: r_cfg.blink_min <= pwdata[RUN_W-1:0];
                REG_BLINK_MAX: r_cfg.blink_max <= pwdata[RUN_W-1:0];
                REG_WARN:      r_cfg.warn      <= pwdata[RUN_W-1:0];
                REG_ALARM:     r_cfg.alarm     <= pwdata[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MIN_DIST:  prdata = DATA_W'(r_cfg.min_dist);
            REG_WARMUP:    prdata = DATA_W'(r_cfg.warmup);
            REG_DROP:      prdata = DATA_W'(r_cfg.drop);
            REG_BLINK_MIN: prdata = DATA_W'(r_cfg.blink_min);
            REG_BLINK_MAX: prdata = DATA_W'(r_cfg.blink_max);
            REG_WARN:      prdata = DATA_W'(r_cfg.warn);
            REG_ALARM:     prdata = DATA_W'(r_cfg.alarm);
            default:       prdata = '0;
        endcase
    end

    assign w_frame.top[0][0] = i_left_top_y_1;
    assign w_frame.top[0][1] = i_left_top_y_2;
    assign w_frame.top[0][2] = i_left_top_y_3;
    assign w_frame.bot[0][0] = i_left_bottom_y_1;
    assign w_frame.bot[0][1] = i_left_bottom_y_2;
    assign w_frame.bot[0][2] = i_left_bottom_y_3;
    assign w_frame.top[1][0] = i_right_top_y_1;
    assign w_frame.top[1][1] = i_right_top_y_2;
    assign w_frame.top[1][2] = i_right_top_y_3;
    assign w_frame.bot[1][0] = i_right_bottom_y_1;
    assign w_frame.bot[1][1] = i_right_bottom_y_2;
    assign w_frame.bot[1][2] = i_right_bottom_y_3;

    ecbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ecbd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_frame           (w_frame),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_danger_level    (o_danger_level),
        .o_aperture        (o_aperture),
        .o_history_average (o_history_average),
        .o_eyes_closed     (o_eyes_closed),
        .o_closed_frames   (o_closed_frames),
        .o_blink_count     (o_blink_count)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input side not stalled after a beat was accepted");

    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !w_stat.div_done)
        else $error("divider reports done right after start");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("output valid rose without a result load");

    a_load_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a stalled output beat");

endmodule
